/* rtl/gbfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_pkg
// shared constants, types and the neighbour step function for the grid breadth-first search block
// ----------------------------------------------------------------------------
package gbfs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 32;
    localparam int NTILES      = GRID_WIDTH * GRID_HEIGHT;
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int ROW_W       = $clog2(GRID_HEIGHT);
    localparam int TILE_W      = COL_W + ROW_W;
    localparam int CNT_W       = TILE_W + 1;
    localparam int DEPTH_W     = 11;
    localparam int PARENT_W    = 12;

    localparam logic [PARENT_W-1:0] NO_PARENT = '1;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [3:0] DIR_W  = 4'd0;
    localparam logic [3:0] DIR_E  = 4'd1;
    localparam logic [3:0] DIR_N  = 4'd2;
    localparam logic [3:0] DIR_S  = 4'd3;
    localparam logic [3:0] DIR_NW = 4'd4;
    localparam logic [3:0] DIR_SW = 4'd5;
    localparam logic [3:0] DIR_NE = 4'd6;
    localparam logic [3:0] DIR_SE = 4'd7;
    localparam logic [3:0] DIR_END = 4'd8;

    typedef struct packed {
        logic                visited;
        logic [PARENT_W-1:0] parent;
        logic [DEPTH_W-1:0]  depth;
    } node_t;

    typedef struct packed {
        logic              ok;
        logic [TILE_W-1:0] tile;
    } nbr_t;

    function automatic nbr_t step_tile(input logic [TILE_W-1:0] cur, input logic [3:0] dir);
        logic [COL_W-1:0] cx;
        logic [ROW_W-1:0] cy;
        logic             w_ok;
        logic             e_ok;
        logic             n_ok;
        logic             s_ok;
        logic [COL_W-1:0] nx;
        logic [ROW_W-1:0] ny;
        nbr_t             r;
        cx   = cur[COL_W-1:0];
        cy   = cur[TILE_W-1:COL_W];
        w_ok = (cx != '0);
        e_ok = (cx != COL_W'(GRID_WIDTH - 1));
        n_ok = (cy != '0);
        s_ok = (cy != ROW_W'(GRID_HEIGHT - 1));
        nx   = cx;
        ny   = cy;
        r.ok = 1'b0;
        case (dir)
            DIR_W:  begin r.ok = w_ok;        nx = cx - 1'b1; end
            DIR_E:  begin r.ok = e_ok;        nx = cx + 1'b1; end
            DIR_N:  begin r.ok = n_ok;        ny = cy - 1'b1; end
            DIR_S:  begin r.ok = s_ok;        ny = cy + 1'b1; end
            DIR_NW: begin r.ok = w_ok & n_ok; nx = cx - 1'b1; ny = cy - 1'b1; end
            DIR_SW: begin r.ok = w_ok & s_ok; nx = cx - 1'b1; ny = cy + 1'b1; end
            DIR_NE: begin r.ok = e_ok & n_ok; nx = cx + 1'b1; ny = cy - 1'b1; end
            DIR_SE: begin r.ok = e_ok & s_ok; nx = cx + 1'b1; ny = cy + 1'b1; end
            default: r.ok = 1'b0;
        endcase
        r.tile = {ny, nx};
        return r;
    endfunction

endpackage

/* rtl/gbfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module gbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_bfs_path_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bfs_path_map
// breadth-first search over an 8-connected 64 x 32 tile grid
//
// a word is taken when start is high and busy is low. op 0 loads a tile's
// exit mask and occupied bit, op 1 runs a search from root_index, op 2
// queries the parent, depth and visited mark of a tile. every word gives
// one result, shown for one cycle with done high; the receiver cannot stall.
// load and other codes answer in the cycle after the word, a query from
// S_QOUT. a search first sweeps the node ram, then pops each reached tile
// from the queue ram, reads its tile and node entries and, unless the tile
// is occupied, not the root and occupants are not ignored, probes its eight
// neighbours one per cycle through the node ram. after reset the node ram
// is swept once with busy high. ignore_occupants is written over cfg_valid /
// cfg_ready / cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce; cfg_ready is always high.
// ----------------------------------------------------------------------------
module grid_bfs_path_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [gbfs_pkg::TILE_W-1:0]  tile_index,
    input  logic [7:0]                   exit_mask,
    input  logic                         occupied,
    input  logic [gbfs_pkg::TILE_W-1:0]  root_index,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    output logic                         done,
    output logic [gbfs_pkg::CNT_W-1:0]   reached_count,
    output logic                         visited_flag,
    output logic                         has_parent,
    output logic [gbfs_pkg::TILE_W-1:0]  parent_index,
    output logic [gbfs_pkg::DEPTH_W-1:0] depth
);

    import gbfs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_FETCH = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_QOUT  = 4'd7;

    localparam int NODE_W = $bits(node_t);

    logic [3:0]          state_reg, state_next;
    logic                search_reg, search_next;
    logic                ignore_reg;
    logic [TILE_W-1:0]   clr_reg, clr_next;
    logic [TILE_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic [TILE_W-1:0]   cur_reg, cur_next;
    logic [7:0]          exit_reg, exit_next;
    logic [DEPTH_W-1:0]  cdep_reg, cdep_next;
    logic [3:0]          dir_reg, dir_next;
    nbr_t                pend_reg, pend_next;
    logic [CNT_W-1:0]    reached_reg, reached_next;
    logic                done_reg, done_next;
    logic                vis_reg, vis_next;
    logic                hasp_reg, hasp_next;
    logic [TILE_W-1:0]   par_reg, par_next;
    logic [DEPTH_W-1:0]  dep_reg, dep_next;

    logic                accept;
    nbr_t                nbr;

    logic                tile_we;
    logic [8:0]          tile_rdata;
    logic                node_we;
    logic [TILE_W-1:0]   node_waddr;
    node_t               node_wdata;
    logic [TILE_W-1:0]   node_raddr;
    logic [NODE_W-1:0]   node_rbits;
    node_t               node_rdata;
    logic                q_we;
    logic [TILE_W-1:0]   q_waddr;
    logic [TILE_W-1:0]   q_wdata;
    logic [TILE_W-1:0]   q_rdata;

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = start & ~busy;
    assign done          = done_reg;
    assign reached_count = reached_reg;
    assign visited_flag  = vis_reg;
    assign has_parent    = hasp_reg;
    assign parent_index  = par_reg;
    assign depth         = dep_reg;
    assign node_rdata    = node_t'(node_rbits);
    assign nbr           = step_tile(cur_reg, dir_reg);
    assign tile_we       = accept && (op == OP_LOAD);

    gbfs_ram #(.WIDTH(9), .DEPTH(NTILES)) u_tile_ram (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_index),
        .wdata ({occupied, exit_mask}),
        .raddr (q_rdata),
        .rdata (tile_rdata)
    );

    gbfs_ram #(.WIDTH(NODE_W), .DEPTH(NTILES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rbits)
    );

    gbfs_ram #(.WIDTH(TILE_W), .DEPTH(NTILES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[TILE_W-1:0]),
        .rdata (q_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        search_next  = search_reg;
        clr_next     = clr_reg;
        root_next    = root_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        exit_next    = exit_reg;
        cdep_next    = cdep_reg;
        dir_next     = dir_reg;
        pend_next    = pend_reg;
        reached_next = reached_reg;
        done_next    = 1'b0;
        vis_next     = vis_reg;
        hasp_next    = hasp_reg;
        par_next     = par_reg;
        dep_next     = dep_reg;

        node_we    = 1'b0;
        node_waddr = clr_reg;
        node_wdata = '{visited: 1'b0, parent: NO_PARENT, depth: '0};
        node_raddr = tile_index;
        q_we       = 1'b0;
        q_waddr    = tail_reg[TILE_W-1:0];
        q_wdata    = root_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    vis_next  = 1'b0;
                    hasp_next = 1'b0;
                    par_next  = '0;
                    dep_next  = '0;
                    case (op)
                        OP_SEARCH:
                        begin
                            root_next   = root_index;
                            search_next = 1'b1;
                            clr_next    = '0;
                            state_next  = S_CLEAR;
                        end
                        OP_QUERY:
                        begin
                            state_next = S_QOUT;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                node_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TILE_W'(NTILES - 1))
                begin
                    state_next = search_reg ? S_ROOT : S_IDLE;
                end
            end
            S_ROOT:
            begin
                node_we    = 1'b1;
                node_waddr = root_reg;
                node_wdata = '{visited: 1'b1, parent: NO_PARENT, depth: '0};
                q_we       = 1'b1;
                q_waddr    = '0;
                head_next  = '0;
                tail_next  = CNT_W'(1);
                state_next = S_POP;
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    reached_next = tail_reg;
                    search_next  = 1'b0;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                node_raddr = q_rdata;
                cur_next   = q_rdata;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                exit_next  = tile_rdata[7:0];
                cdep_next  = node_rdata.depth;
                dir_next   = DIR_W;
                pend_next  = '{ok: 1'b0, tile: '0};
                if (tile_rdata[8] && (cur_reg != root_reg) && !ignore_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // probe this neighbour, settle the one probed last cycle
                node_raddr = nbr.tile;
                pend_next  = '{ok: nbr.ok & exit_reg[dir_reg[2:0]] & (dir_reg != DIR_END),
                               tile: nbr.tile};
                if (pend_reg.ok && !node_rdata.visited)
                begin
                    node_we    = 1'b1;
                    node_waddr = pend_reg.tile;
                    node_wdata = '{visited: 1'b1,
                                   parent:  {1'b0, cur_reg},
                                   depth:   cdep_reg + 1'b1};
                    q_we       = 1'b1;
                    q_wdata    = pend_reg.tile;
                    tail_next  = tail_reg + 1'b1;
                end
                if (dir_reg == DIR_END)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            S_QOUT:
            begin
                vis_next   = node_rdata.visited;
                hasp_next  = (node_rdata.parent != NO_PARENT);
                par_next   = (node_rdata.parent != NO_PARENT) ?
                             node_rdata.parent[TILE_W-1:0] : '0;
                dep_next   = node_rdata.depth;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            search_reg  <= 1'b0;
            clr_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            dir_reg     <= DIR_W;
            pend_reg    <= '{ok: 1'b0, tile: '0};
            reached_reg <= '0;
            done_reg    <= 1'b0;
            ignore_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            search_reg  <= search_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            dir_reg     <= dir_next;
            pend_reg    <= pend_next;
            reached_reg <= reached_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                ignore_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
        cur_reg  <= cur_next;
        exit_reg <= exit_next;
        cdep_reg <= cdep_next;
        vis_reg  <= vis_next;
        hasp_reg <= hasp_next;
        par_reg  <= par_next;
        dep_reg  <= dep_next;
    end

endmodule

/* tb/tb_grid_bfs_path_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_bfs_path_map
// self-checking bench for the grid breadth-first search block
//
// every tile is loaded first. Then come a directed list, and random loads,
// searches, queries and unused op codes under both occupant modes. A
// scoreboard class floods its own copy of the grid on each search and
// predicts every result word. Done words are compared field by field, in
// order. A watchdog ends the run if no handshake is seen for too long.
// ----------------------------------------------------------------------------
module tb_grid_bfs_path_map;

    import gbfs_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int         STALL_LIMIT = 200000;

    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        logic               vis;
        logic               hasp;
        logic [TILE_W-1:0]  par;
        logic [DEPTH_W-1:0] dep;
    } bfs_word_t;

    class bfs_scoreboard;
        bit [7:0]          exit_m[NTILES];
        bit                occ_m[NTILES];
        bit                vis_m[NTILES];
        bit [PARENT_W-1:0] par_m[NTILES];
        bit [DEPTH_W-1:0]  dep_m[NTILES];
        int                fifo[NTILES];
        int unsigned       reached;
        bit                flood;
        bfs_word_t         pending[$];
        int                errors;

        function new();
            clear_nodes();
            reached = 0;
            flood   = 0;
            errors  = 0;
        endfunction

        function void clear_nodes();
            for (int i = 0; i < NTILES; i++)
            begin
                vis_m[i] = 0;
                par_m[i] = NO_PARENT;
                dep_m[i] = '0;
            end
        endfunction

        function void flood_from(int root);
            int dx[8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
            int dy[8] = '{0, 0, -1, 1, -1, 1, -1, 1};
            int head;
            int tail;
            int cur;
            int nx;
            int ny;
            int nb;
            clear_nodes();
            head = 0;
            tail = 0;
            vis_m[root] = 1;
            fifo[tail++] = root;
            while (head < tail)
            begin
                cur = fifo[head++];
                if (occ_m[cur] && cur != root && !flood)
                    continue;
                for (int n = 0; n < 8; n++)
                begin
                    nx = cur % GRID_WIDTH + dx[n];
                    ny = cur / GRID_WIDTH + dy[n];
                    if (!exit_m[cur][n])
                        continue;
                    if (nx < 0 || nx >= GRID_WIDTH || ny < 0 || ny >= GRID_HEIGHT)
                        continue;
                    nb = ny * GRID_WIDTH + nx;
                    if (vis_m[nb])
                        continue;
                    vis_m[nb] = 1;
                    par_m[nb] = PARENT_W'(cur);
                    dep_m[nb] = dep_m[cur] + 1'b1;
                    if (tail < NTILES)
                        fifo[tail++] = nb;
                end
            end
            reached = tail;
        endfunction

        function void note_word(logic [1:0] op, int tile, logic [7:0] mask, logic occ,
                                int root);
            bfs_word_t w;
            w = '0;
            case (op)
                OP_LOAD:
                begin
                    exit_m[tile] = mask;
                    occ_m[tile]  = occ;
                end
                OP_SEARCH: flood_from(root);
                OP_QUERY:
                begin
                    w.vis = vis_m[tile];
                    if (par_m[tile] != NO_PARENT)
                    begin
                        w.hasp = 1;
                        w.par  = par_m[tile][TILE_W-1:0];
                    end
                    w.dep = dep_m[tile];
                end
                default: ;
            endcase
            w.cnt = CNT_W'(reached);
            pending.push_back(w);
        endfunction

        function void check(bfs_word_t got);
            bfs_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.cnt != want.cnt)
                $display("%0t reached_count exp %0d got %0d", $time, want.cnt, got.cnt);
            if (got.vis != want.vis)
                $display("%0t visited_flag exp %0d got %0d", $time, want.vis, got.vis);
            if (got.hasp != want.hasp)
                $display("%0t has_parent exp %0d got %0d", $time, want.hasp, got.hasp);
            if (got.par != want.par)
                $display("%0t parent_index exp %0d got %0d", $time, want.par, got.par);
            if (got.dep != want.dep)
                $display("%0t depth exp %0d got %0d", $time, want.dep, got.dep);
            if (got != want)
                errors++;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           op;
    logic [TILE_W-1:0]    tile_index;
    logic [7:0]           exit_mask;
    logic                 occupied;
    logic [TILE_W-1:0]    root_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    logic                 done;
    logic [CNT_W-1:0]     reached_count;
    logic                 visited_flag;
    logic                 has_parent;
    logic [TILE_W-1:0]    parent_index;
    logic [DEPTH_W-1:0]   depth;

    bfs_scoreboard sb;
    int            stall_cnt;
    int            last_root;

    grid_bfs_path_map u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .tile_index    (tile_index),
        .exit_mask     (exit_mask),
        .occupied      (occupied),
        .root_index    (root_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .reached_count (reached_count),
        .visited_flag  (visited_flag),
        .has_parent    (has_parent),
        .parent_index  (parent_index),
        .depth         (depth)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check({reached_count, visited_flag, has_parent, parent_index, depth});
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT)
        begin
            $display("grid_bfs_path_map verification failed");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] o, int tile, logic [7:0] mask, logic occ, int root,
                             bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        tile_index <= TILE_W'(tile);
        exit_mask  <= mask;
        occupied   <= occ;
        root_index <= TILE_W'(root);
        do
            @(posedge clk);
        while (busy);
        sb.note_word(o, tile, mask, occ, root);
        if (o == OP_SEARCH)
            last_root = root;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.flood = v;
    endtask

    // query near the last root so that reached tiles are hit often
    function automatic int near_tile();
        return (last_root + $urandom_range(0, 260) - 130 + NTILES) % NTILES;
    endfunction

    initial
    begin
        int  t;
        int  r;
        bit  idle_ok;
        sb         = new();
        stall_cnt  = 0;
        last_root  = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_LOAD;
        tile_index = '0;
        exit_mask  = '0;
        occupied   = 1'b0;
        root_index = '0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole grid with dense random exits
        for (int i = 0; i < NTILES; i++)
            send_word(OP_LOAD, i, 8'($urandom | $urandom), $urandom_range(0, 7) == 0,
                      0, 0);

        // directed corners, full and empty masks, occupied root, op three
        send_word(OP_LOAD, 0, 8'hFF, 1'b1, 0, 1);
        send_word(OP_LOAD, NTILES - 1, 8'hFF, 1'b1, 0, 1);
        send_word(OP_LOAD, GRID_WIDTH - 1, 8'h00, 1'b0, 0, 1);
        send_word(OP_LOAD, NTILES - GRID_WIDTH, 8'hAA, 1'b1, 0, 1);
        send_word(OP_LOAD, 1, 8'h55, 1'b1, 0, 1);
        send_word(OP_SEARCH, 0, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, 0, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, 1, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, GRID_WIDTH + 1, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, NTILES - 1, 8'h00, 1'b0, 0, 1);
        send_word(OP_NONE, NTILES - 1, 8'hFF, 1'b1, NTILES - 1, 1);
        send_word(OP_SEARCH, 0, 8'h00, 1'b0, GRID_WIDTH - 1, 1);
        send_word(OP_QUERY, GRID_WIDTH - 1, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, GRID_WIDTH - 2, 8'h00, 1'b0, 0, 1);
        write_mode(1'b1);
        send_word(OP_SEARCH, 0, 8'h00, 1'b0, NTILES - 1, 1);
        send_word(OP_QUERY, 0, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, NTILES - 2, 8'h00, 1'b0, 0, 1);
        send_word(OP_QUERY, NTILES - GRID_WIDTH, 8'h00, 1'b0, 0, 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode(ph[0]);
            for (int k = 0; k < 25; k++)
            begin
                idle_ok = (ph < 3);
                r = $urandom_range(0, 99);
                t = $urandom_range(0, NTILES - 1);
                if (r < 10)
                    send_word(OP_SEARCH, t, 8'($urandom), 1'b0,
                              $urandom_range(0, NTILES - 1), idle_ok);
                else if (r < 35)
                    send_word(OP_LOAD, t, 8'($urandom | $urandom),
                              $urandom_range(0, 4) == 0, 0, idle_ok);
                else if (r < 38)
                    send_word(OP_NONE, t, 8'($urandom), 1'($urandom),
                              $urandom_range(0, NTILES - 1), idle_ok);
                else if (r < 48)
                    send_word(OP_QUERY, t, 8'h00, 1'b0, 0, idle_ok);
                else
                    send_word(OP_QUERY, near_tile(), 8'h00, 1'b0, 0, idle_ok);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("grid_bfs_path_map verification clean");
        else
            $display("grid_bfs_path_map verification failed");
        $finish;
    end

endmodule
